FILE: hdl/adjacency_matrix_graph_engine_unit_assert.svh
// ---------------------------------------------------------------------------
// Graph engine assertion macros
// Short forms for concurrent assertions clocked on clk with reset arst_n.
// ---------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_GRAPH_ENGINE_UNIT_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define AMG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("graph engine assertion failed");

// Next-cycle implication.
`define AMG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("graph engine assertion failed");

`endif

FILE: hdl/amg_pkg.sv
// ---------------------------------------------------------------------------
// Graph engine package
// Action codes, status codes and sequencer states of the graph engine.
// ---------------------------------------------------------------------------
package amg_pkg;

	localparam logic [3:0] ACT_ADD_VERTEX = 4'd0;
	localparam logic [3:0] ACT_INSERT     = 4'd1;
	localparam logic [3:0] ACT_SET_WEIGHT = 4'd2;
	localparam logic [3:0] ACT_DEL_EDGE   = 4'd3;
	localparam logic [3:0] ACT_GET_WEIGHT = 4'd4;
	localparam logic [3:0] ACT_ADJACENT   = 4'd5;
	localparam logic [3:0] ACT_FIRST_NB   = 4'd6;
	localparam logic [3:0] ACT_NEXT_NB    = 4'd7;
	localparam logic [3:0] ACT_DEL_VERTEX = 4'd8;
	localparam logic [3:0] ACT_POWER      = 4'd9;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	localparam logic [6:0] EDGE_LIMIT = 7'd64;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LOOK,
		S_EXEC,
		S_WR2,
		S_RDW,
		S_SCAN_RD,
		S_SCAN_CK,
		S_CNT_RD,
		S_CNT_CK,
		S_CMP_RD,
		S_CMP_WR,
		S_CPY_RD,
		S_CPY_WR,
		S_MUL_RD,
		S_MUL_GO,
		S_MUL_WAIT,
		S_ROW_WR,
		S_STR_RD,
		S_STR_OUT,
		S_EMIT
	} state_t;

endpackage

FILE: hdl/amg_if.sv
// ---------------------------------------------------------------------------
// Graph engine channel interfaces
// Request, result and mode-register channels with valid and ready.
// ---------------------------------------------------------------------------
interface amg_in_if;
	logic               valid;
	logic               ready;
	logic        [3:0]  action;
	logic        [7:0]  name_a;
	logic        [7:0]  name_b;
	logic signed [15:0] weight;
	logic        [3:0]  extra_products;
	modport source (output valid, action, name_a, name_b, weight, extra_products,
		input ready);
	modport sink (input valid, action, name_a, name_b, weight, extra_products,
		output ready);
endinterface

interface amg_out_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic               flag;
	logic        [2:0]  neighbour_index;
	logic signed [63:0] value;
	logic        [2:0]  row;
	logic        [2:0]  col;
	logic        [6:0]  edge_total;
	logic               last;
	modport source (output valid, status, flag, neighbour_index, value, row, col,
		edge_total, last, input ready);
	modport sink (input valid, status, flag, neighbour_index, value, row, col,
		edge_total, last, output ready);
endinterface

interface amg_cfg_if;
	logic valid;
	logic ready;
	logic directed_mode;
	modport source (output valid, directed_mode, input ready);
	modport sink (input valid, directed_mode, output ready);
endinterface

FILE: hdl/adjacency_matrix_graph_engine_unit.sv
// ---------------------------------------------------------------------------
// Adjacency matrix graph engine
// Keeps vertex names and a weighted adjacency matrix and serves requests.
// ---------------------------------------------------------------------------
// The request channel in_ch takes one word per request; ready is high only
// while the engine is idle. Each request gives one result word on out_ch,
// except the power request, which streams n*n words row-major (last marks
// the final one). The cfg channel writes the directed_mode register and is
// always ready; write it only while the engine is idle.
// Edge requests first look up both names; neighbour scans walk the row
// entry by entry; vertex deletion counts the edges of the vertex (its row,
// and also its column in directed mode), then compacts the matrix. The
// power request copies the matrix to the scratch RAM, then forms each extra
// product with the shared 32 x 32 multiplier, which builds each 64-bit
// product from three partial products, then streams the words out.
// Reset empties the graph and clears the matrix and mode at once. A stalled
// receiver holds the result word in the output register; the engine can
// start the next request but waits in S_EMIT or S_STR_OUT before the next word.
// ---------------------------------------------------------------------------
module adjacency_matrix_graph_engine_unit #(
	parameter int MAX_VERTICES = 8,
	parameter int WEIGHT_BITS  = 16
) (
	input logic         clk,
	input logic         arst_n,
	amg_in_if.sink      in_ch,
	amg_out_if.source   out_ch,
	amg_cfg_if.sink     cfg
);

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam int AW    = 2 * VW;
	localparam int DEPTH = 1 << AW;

	amg_pkg::state_t state_q, state_d;

	logic [3:0]             act_q;
	logic [7:0]             na_q, nb_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [3:0]             k_q, kc_q;
	logic [VW-1:0]          a_q, b_q;
	logic                   a_ok_q, b_ok_q;
	logic [CW-1:0]          i_q, j_q, m_q, cnt_q;
	logic [6:0]             ecount_q, inc_q;
	logic                   dir_q, colph_q;
	logic [7:0]             names_q [MAX_VERTICES];
	logic [63:0]            rowbuf_q [MAX_VERTICES];
	logic [63:0]            acc_q;
	logic [DEPTH-1:0]       vld_q;
	logic                   rvld_q;
	logic [1:0]             rstat_q;
	logic                   rflag_q;
	logic [VW-1:0]          rnb_q;
	logic [63:0]            rval_q;

	logic                   out_valid_q, out_flag_q, out_last_q;
	logic [1:0]             out_status_q;
	logic [2:0]             out_nb_q, out_row_q, out_col_q;
	logic [63:0]            out_value_q;
	logic [6:0]             out_total_q;

	logic                   we_e, we_p, mac_start, mac_done, out_free;
	logic [AW-1:0]          waddr_e, raddr_e, waddr_p, raddr_p;
	logic [WEIGHT_BITS-1:0] wdata_e, rdata_e, edge_rd;
	logic [63:0]            wdata_p, rdata_p, mac_prod, edge_ext, acc_sum;
	logic signed [31:0]     wide_w;
	logic [7:0]             cur_name;
	logic                   ma, mb, look_done, last_i, last_j, last_m, nz;
	logic [CW-1:0]          nm1, src_r, src_c, b_next;
	logic                   accept;
	logic                   cnt_hit;
	logic [6:0]             inc_d;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign wide_w   = 32'(in_ch.weight);
	assign cur_name = names_q[i_q[VW-1:0]];
	assign ma       = cur_name == na_q;
	assign mb       = cur_name == nb_q;
	assign look_done = ((a_ok_q || ma) && (b_ok_q || mb)) || last_i;
	assign last_i   = (i_q + CW'(1)) == cnt_q;
	assign last_j   = (j_q + CW'(1)) == cnt_q;
	assign last_m   = (m_q + CW'(1)) == cnt_q;
	assign nm1      = cnt_q - CW'(1);
	assign b_next   = CW'(b_q) + CW'(1);
	assign src_r    = (i_q >= CW'(a_q)) ? i_q + CW'(1) : i_q;
	assign src_c    = (j_q >= CW'(a_q)) ? j_q + CW'(1) : j_q;
	assign edge_rd  = rvld_q ? rdata_e : '0;
	assign nz       = |edge_rd;
	assign edge_ext = 64'(signed'(edge_rd));
	assign acc_sum  = acc_q + mac_prod;
	assign cnt_hit  = nz && !(colph_q && i_q[VW-1:0] == a_q);
	assign inc_d    = inc_q + {6'd0, cnt_hit};

	amg_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_edge_ram (
		.clk(clk), .we(we_e), .waddr(waddr_e), .wdata(wdata_e),
		.raddr(raddr_e), .rdata(rdata_e)
	);

	amg_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_scratch_ram (
		.clk(clk), .we(we_p), .waddr(waddr_p), .wdata(wdata_p),
		.raddr(raddr_p), .rdata(rdata_p)
	);

	amg_mac u_mac (
		.clk(clk), .arst_n(arst_n), .start(mac_start),
		.op_a(rdata_p), .op_b(edge_ext), .done(mac_done), .prod(mac_prod)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			amg_pkg::S_IDLE: begin
				if (accept) begin
					if (in_ch.action == amg_pkg::ACT_POWER) begin
						state_d = (cnt_q == '0) ? amg_pkg::S_EMIT : amg_pkg::S_CPY_RD;
					end else if (in_ch.action >= amg_pkg::ACT_INSERT &&
						in_ch.action <= amg_pkg::ACT_DEL_VERTEX && cnt_q != '0) begin
						state_d = amg_pkg::S_LOOK;
					end else begin
						state_d = amg_pkg::S_EXEC;
					end
				end
			end
			amg_pkg::S_LOOK: begin
				if (look_done) state_d = amg_pkg::S_EXEC;
			end
			amg_pkg::S_EXEC: begin
				case (act_q)
					amg_pkg::ACT_INSERT, amg_pkg::ACT_SET_WEIGHT, amg_pkg::ACT_DEL_EDGE: begin
						state_d = (a_ok_q && b_ok_q && !dir_q) ? amg_pkg::S_WR2 : amg_pkg::S_EMIT;
					end
					amg_pkg::ACT_GET_WEIGHT, amg_pkg::ACT_ADJACENT: begin
						state_d = (a_ok_q && b_ok_q) ? amg_pkg::S_RDW : amg_pkg::S_EMIT;
					end
					amg_pkg::ACT_FIRST_NB: begin
						state_d = a_ok_q ? amg_pkg::S_SCAN_RD : amg_pkg::S_EMIT;
					end
					amg_pkg::ACT_NEXT_NB: begin
						state_d = (a_ok_q && b_ok_q && b_next < cnt_q) ?
							amg_pkg::S_SCAN_RD : amg_pkg::S_EMIT;
					end
					amg_pkg::ACT_DEL_VERTEX: begin
						state_d = a_ok_q ? amg_pkg::S_CNT_RD : amg_pkg::S_EMIT;
					end
					default: state_d = amg_pkg::S_EMIT;
				endcase
			end
			amg_pkg::S_WR2: state_d = amg_pkg::S_EMIT;
			amg_pkg::S_RDW: state_d = amg_pkg::S_EMIT;
			amg_pkg::S_SCAN_RD: state_d = amg_pkg::S_SCAN_CK;
			amg_pkg::S_SCAN_CK: begin
				state_d = (nz || last_i) ? amg_pkg::S_EMIT : amg_pkg::S_SCAN_RD;
			end
			amg_pkg::S_CNT_RD: state_d = amg_pkg::S_CNT_CK;
			amg_pkg::S_CNT_CK: begin
				state_d = (last_i && (colph_q || !dir_q)) ? amg_pkg::S_CMP_RD : amg_pkg::S_CNT_RD;
			end
			amg_pkg::S_CMP_RD: state_d = amg_pkg::S_CMP_WR;
			amg_pkg::S_CMP_WR: begin
				state_d = (last_i && last_j) ? amg_pkg::S_EMIT : amg_pkg::S_CMP_RD;
			end
			amg_pkg::S_CPY_RD: state_d = amg_pkg::S_CPY_WR;
			amg_pkg::S_CPY_WR: begin
				if (last_i && last_j) begin
					state_d = (k_q == '0) ? amg_pkg::S_STR_RD : amg_pkg::S_MUL_RD;
				end else begin
					state_d = amg_pkg::S_CPY_RD;
				end
			end
			amg_pkg::S_MUL_RD: state_d = amg_pkg::S_MUL_GO;
			amg_pkg::S_MUL_GO: state_d = amg_pkg::S_MUL_WAIT;
			amg_pkg::S_MUL_WAIT: begin
				if (mac_done) begin
					state_d = (last_m && last_j) ? amg_pkg::S_ROW_WR : amg_pkg::S_MUL_RD;
				end
			end
			amg_pkg::S_ROW_WR: begin
				if (last_j) begin
					if (last_i && (kc_q + 4'd1) == k_q) begin
						state_d = amg_pkg::S_STR_RD;
					end else begin
						state_d = amg_pkg::S_MUL_RD;
					end
				end
			end
			amg_pkg::S_STR_RD: state_d = amg_pkg::S_STR_OUT;
			amg_pkg::S_STR_OUT: begin
				if (out_free) begin
					state_d = (last_i && last_j) ? amg_pkg::S_IDLE : amg_pkg::S_STR_RD;
				end
			end
			amg_pkg::S_EMIT: begin
				if (out_free) state_d = amg_pkg::S_IDLE;
			end
			default: state_d = amg_pkg::S_IDLE;
		endcase
	end

	// Memory, multiplier and handshake controls.
	always_comb begin
		in_ch.ready = 1'b0;
		we_e        = 1'b0;
		waddr_e     = {a_q, b_q};
		wdata_e     = w_q;
		raddr_e     = {a_q, b_q};
		we_p        = 1'b0;
		waddr_p     = {i_q[VW-1:0], j_q[VW-1:0]};
		wdata_p     = edge_ext;
		raddr_p     = {i_q[VW-1:0], j_q[VW-1:0]};
		mac_start   = 1'b0;
		case (state_q)
			amg_pkg::S_IDLE: in_ch.ready = 1'b1;
			amg_pkg::S_EXEC: begin
				if (a_ok_q && b_ok_q && (act_q == amg_pkg::ACT_INSERT ||
					act_q == amg_pkg::ACT_SET_WEIGHT || act_q == amg_pkg::ACT_DEL_EDGE)) begin
					we_e    = 1'b1;
					wdata_e = (act_q == amg_pkg::ACT_DEL_EDGE) ? '0 : w_q;
				end
			end
			amg_pkg::S_WR2: begin
				we_e    = 1'b1;
				waddr_e = {b_q, a_q};
				wdata_e = (act_q == amg_pkg::ACT_DEL_EDGE) ? '0 : w_q;
			end
			amg_pkg::S_SCAN_RD: raddr_e = {a_q, i_q[VW-1:0]};
			amg_pkg::S_CNT_RD: begin
				raddr_e = colph_q ? {i_q[VW-1:0], a_q} : {a_q, i_q[VW-1:0]};
			end
			amg_pkg::S_CMP_RD: raddr_e = {src_r[VW-1:0], src_c[VW-1:0]};
			amg_pkg::S_CMP_WR: begin
				we_e    = 1'b1;
				waddr_e = {i_q[VW-1:0], j_q[VW-1:0]};
				wdata_e = (i_q == nm1 || j_q == nm1) ? '0 : edge_rd;
			end
			amg_pkg::S_CPY_RD: raddr_e = {i_q[VW-1:0], j_q[VW-1:0]};
			amg_pkg::S_CPY_WR: we_p = 1'b1;
			amg_pkg::S_MUL_RD: begin
				raddr_p = {i_q[VW-1:0], m_q[VW-1:0]};
				raddr_e = {m_q[VW-1:0], j_q[VW-1:0]};
			end
			amg_pkg::S_MUL_GO: mac_start = 1'b1;
			amg_pkg::S_ROW_WR: begin
				we_p    = 1'b1;
				wdata_p = rowbuf_q[j_q[VW-1:0]];
			end
			default: begin
				we_e = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= amg_pkg::S_IDLE;
			cnt_q       <= '0;
			ecount_q    <= '0;
			dir_q       <= 1'b0;
			vld_q       <= '0;
			rvld_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rvld_q  <= vld_q[raddr_e];
			if (we_e) vld_q[waddr_e] <= 1'b1;
			if (cfg.valid && cfg.ready) dir_q <= cfg.directed_mode;
			if (out_ch.ready) out_valid_q <= 1'b0;
			if ((state_q == amg_pkg::S_EMIT || state_q == amg_pkg::S_STR_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end
			if (state_q == amg_pkg::S_EXEC) begin
				if (act_q == amg_pkg::ACT_ADD_VERTEX && cnt_q != CW'(MAX_VERTICES)) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (a_ok_q && b_ok_q) begin
					if (act_q == amg_pkg::ACT_INSERT && ecount_q < amg_pkg::EDGE_LIMIT) begin
						ecount_q <= ecount_q + 7'd1;
					end
					if (act_q == amg_pkg::ACT_DEL_EDGE && ecount_q != '0) begin
						ecount_q <= ecount_q - 7'd1;
					end
				end
			end
			if (state_q == amg_pkg::S_CNT_CK && state_d == amg_pkg::S_CMP_RD) begin
				ecount_q <= (ecount_q > inc_d) ? ecount_q - inc_d : '0;
			end
			if (state_q == amg_pkg::S_CMP_WR && last_i && last_j) begin
				cnt_q <= nm1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			amg_pkg::S_IDLE: begin
				act_q   <= in_ch.action;
				na_q    <= in_ch.name_a;
				nb_q    <= in_ch.name_b;
				w_q     <= wide_w[WEIGHT_BITS-1:0];
				k_q     <= in_ch.extra_products;
				a_ok_q  <= 1'b0;
				b_ok_q  <= 1'b0;
				i_q     <= '0;
				j_q     <= '0;
				m_q     <= '0;
				kc_q    <= '0;
				acc_q   <= '0;
				inc_q   <= '0;
				colph_q <= 1'b0;
				rstat_q <= amg_pkg::STAT_OK;
				rflag_q <= 1'b0;
				rnb_q   <= '0;
				rval_q  <= '0;
			end
			amg_pkg::S_LOOK: begin
				if (ma && (act_q == amg_pkg::ACT_INSERT || !a_ok_q)) begin
					a_q    <= i_q[VW-1:0];
					a_ok_q <= 1'b1;
				end
				if (mb && (act_q == amg_pkg::ACT_INSERT || !b_ok_q)) begin
					b_q    <= i_q[VW-1:0];
					b_ok_q <= 1'b1;
				end
				i_q <= look_done ? '0 : i_q + CW'(1);
			end
			amg_pkg::S_EXEC: begin
				case (act_q)
					amg_pkg::ACT_ADD_VERTEX: begin
						if (cnt_q == CW'(MAX_VERTICES)) begin
							rstat_q <= amg_pkg::STAT_FULL;
						end else begin
							names_q[cnt_q[VW-1:0]] <= na_q;
						end
					end
					amg_pkg::ACT_INSERT, amg_pkg::ACT_SET_WEIGHT, amg_pkg::ACT_DEL_EDGE,
					amg_pkg::ACT_GET_WEIGHT, amg_pkg::ACT_ADJACENT: begin
						if (!(a_ok_q && b_ok_q)) rstat_q <= amg_pkg::STAT_MISS;
					end
					amg_pkg::ACT_NEXT_NB: begin
						if (!(a_ok_q && b_ok_q)) rstat_q <= amg_pkg::STAT_MISS;
						i_q <= b_next;
					end
					amg_pkg::ACT_FIRST_NB, amg_pkg::ACT_DEL_VERTEX: begin
						if (!a_ok_q) rstat_q <= amg_pkg::STAT_MISS;
						i_q <= '0;
					end
					default: rstat_q <= amg_pkg::STAT_OK;
				endcase
			end
			amg_pkg::S_RDW: begin
				if (act_q == amg_pkg::ACT_GET_WEIGHT) begin
					rval_q <= edge_ext;
				end else begin
					rflag_q <= nz;
				end
			end
			amg_pkg::S_SCAN_CK: begin
				if (nz) begin
					rflag_q <= 1'b1;
					rnb_q   <= i_q[VW-1:0];
				end
				i_q <= i_q + CW'(1);
			end
			amg_pkg::S_CNT_CK: begin
				if (cnt_hit) inc_q <= inc_d;
				if (last_i) begin
					i_q     <= '0;
					j_q     <= '0;
					colph_q <= 1'b1;
				end else begin
					i_q <= i_q + CW'(1);
				end
			end
			amg_pkg::S_CMP_WR, amg_pkg::S_CPY_WR: begin
				if (last_j) begin
					j_q <= '0;
					i_q <= last_i ? '0 : i_q + CW'(1);
				end else begin
					j_q <= j_q + CW'(1);
				end
				if (state_q == amg_pkg::S_CMP_WR && last_i && last_j) begin
					for (int n = 0; n < MAX_VERTICES - 1; n++) begin
						if (n >= int'(a_q)) names_q[n] <= names_q[n + 1];
					end
				end
			end
			amg_pkg::S_MUL_WAIT: begin
				if (mac_done) begin
					if (last_m) begin
						rowbuf_q[j_q[VW-1:0]] <= acc_sum;
						acc_q <= '0;
						m_q   <= '0;
						j_q   <= last_j ? '0 : j_q + CW'(1);
					end else begin
						acc_q <= acc_sum;
						m_q   <= m_q + CW'(1);
					end
				end
			end
			amg_pkg::S_ROW_WR: begin
				if (last_j) begin
					j_q <= '0;
					if (last_i) begin
						i_q  <= '0;
						kc_q <= kc_q + 4'd1;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end else begin
					j_q <= j_q + CW'(1);
				end
			end
			amg_pkg::S_STR_OUT: begin
				if (out_free) begin
					if (last_j) begin
						j_q <= '0;
						i_q <= i_q + CW'(1);
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == amg_pkg::S_EMIT && out_free) begin
			out_status_q <= rstat_q;
			out_flag_q   <= rflag_q;
			out_nb_q     <= 3'(rnb_q);
			out_value_q  <= rval_q;
			out_row_q    <= '0;
			out_col_q    <= '0;
			out_total_q  <= ecount_q;
			out_last_q   <= 1'b1;
		end else if (state_q == amg_pkg::S_STR_OUT && out_free) begin
			out_status_q <= amg_pkg::STAT_OK;
			out_flag_q   <= 1'b0;
			out_nb_q     <= '0;
			out_value_q  <= rdata_p;
			out_row_q    <= 3'(i_q[VW-1:0]);
			out_col_q    <= 3'(j_q[VW-1:0]);
			out_total_q  <= ecount_q;
			out_last_q   <= last_i && last_j;
		end
	end

	assign cfg.ready              = 1'b1;
	assign out_ch.valid           = out_valid_q;
	assign out_ch.status          = out_status_q;
	assign out_ch.flag            = out_flag_q;
	assign out_ch.neighbour_index = out_nb_q;
	assign out_ch.value           = out_value_q;
	assign out_ch.row             = out_row_q;
	assign out_ch.col             = out_col_q;
	assign out_ch.edge_total      = out_total_q;
	assign out_ch.last            = out_last_q;

endmodule

FILE: hdl/amg_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module amg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/amg_mac.sv
// ---------------------------------------------------------------------------
// Iterative 64-bit multiplier
// Forms the low 64 bits of a product with one shared 32 x 32 multiplier
// over three partial products.
// ---------------------------------------------------------------------------
module amg_mac (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] op_a,
	input  logic [63:0] op_b,
	output logic        done,
	output logic [63:0] prod
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] mul_q;
	logic [63:0] res_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] mx;
	logic [31:0] my;

	always_comb begin
		case (step_q)
			2'd0: begin
				mx = a_q[31:0];
				my = b_q[31:0];
			end
			2'd1: begin
				mx = a_q[63:32];
				my = b_q[31:0];
			end
			default: begin
				mx = a_q[31:0];
				my = b_q[63:32];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			b_q <= op_b;
		end else if (busy_q) begin
			mul_q <= mx * my;
			case (step_q)
				2'd1:    res_q <= mul_q;
				2'd2:    res_q[63:32] <= res_q[63:32] + mul_q[31:0];
				2'd3:    res_q[63:32] <= res_q[63:32] + mul_q[31:0];
				default: res_q <= res_q;
			endcase
		end
	end

	assign done = done_q;
	assign prod = res_q;

endmodule

FILE: hdl/amg_checker.sv
// ---------------------------------------------------------------------------
// Graph engine port checker
// Watches the request and result channels of the graph engine.
// ---------------------------------------------------------------------------
`include "adjacency_matrix_graph_engine_unit_assert.svh"

module amg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_status,
	input logic [6:0] out_edge_total,
	input logic       out_last
);

	`AMG_ASSERT_NEXT(busy_after_accept, in_valid && in_ready, !in_ready)
	`AMG_ASSERT_NEXT(result_held, out_valid && !out_ready, out_valid)
	`AMG_ASSERT_NOW(edge_total_range, out_valid, out_edge_total <= amg_pkg::EDGE_LIMIT)
	`AMG_ASSERT_NOW(error_is_last, out_valid && out_status != amg_pkg::STAT_OK, out_last)

endmodule

bind adjacency_matrix_graph_engine_unit amg_checker u_amg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_status(out_ch.status),
	.out_edge_total(out_ch.edge_total),
	.out_last(out_ch.last)
);
